[hdl/paw_pkg.sv]
// ----------------------------------------------------------------------------
// paw_pkg
// shared types, widths and codes for the pid controller with anti-windup
// ----------------------------------------------------------------------------
`default_nettype none

package paw_pkg;

    // fixed field widths
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int ERR_W      = SAMPLE_W + 1;
    localparam int PROD_W     = GAIN_W + ERR_W;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // parameter defaults
    localparam int DEF_GAIN_FRAC_BITS = 12;
    localparam int DEF_ACC_WIDTH      = 32;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P  = 3'd0,
        REG_GAIN_I  = 3'd1,
        REG_GAIN_D  = 3'd2,
        REG_OUT_MAX = 3'd3,
        REG_OUT_MIN = 3'd4
    } cfg_reg_t;

    // clamp state codes
    typedef enum logic [1:0] {
        SAT_NORMAL = 2'd0,
        SAT_HIGH   = 2'd1,
        SAT_LOW    = 2'd2
    } sat_code_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] setpoint;
        logic signed [SAMPLE_W-1:0] measured;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] drive;
        logic        [1:0]          sat_flag;
    } out_item_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0]   gain_p;
        logic signed [GAIN_W-1:0]   gain_i;
        logic signed [GAIN_W-1:0]   gain_d;
        logic signed [SAMPLE_W-1:0] out_max;
        logic signed [SAMPLE_W-1:0] out_min;
    } cfg_t;

    // products handed from the front end to the core
    typedef struct packed {
        logic signed [PROD_W-1:0] inc;
        logic signed [PROD_W-1:0] pterm;
        logic signed [PROD_W-1:0] dterm;
    } prod_t;

endpackage

`default_nettype wire

[hdl/paw_cfg.sv]
// ----------------------------------------------------------------------------
// paw_cfg
// configuration registers, written through a plain write port
// ----------------------------------------------------------------------------
`default_nettype none

module paw_cfg
    import paw_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_p  <= '0;
            cfg_reg.gain_i  <= '0;
            cfg_reg.gain_d  <= '0;
            cfg_reg.out_max <= {1'b0, {(SAMPLE_W-1){1'b1}}};
            cfg_reg.out_min <= {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else if (cfg_we) begin
            case (cfg_index)
                REG_GAIN_P:  cfg_reg.gain_p  <= cfg_data[GAIN_W-1:0];
                REG_GAIN_I:  cfg_reg.gain_i  <= cfg_data[GAIN_W-1:0];
                REG_GAIN_D:  cfg_reg.gain_d  <= cfg_data[GAIN_W-1:0];
                REG_OUT_MAX: cfg_reg.out_max <= cfg_data[SAMPLE_W-1:0];
                REG_OUT_MIN: cfg_reg.out_min <= cfg_data[SAMPLE_W-1:0];
                default: ; // unused indexes are ignored
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[hdl/paw_front.sv]
// ----------------------------------------------------------------------------
// paw_front
// input register (error and measurement difference) and product register
// ----------------------------------------------------------------------------
`default_nettype none

module paw_front
    import paw_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = DEF_GAIN_FRAC_BITS
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire cfg_t     cfg,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    output logic          p_valid,
    input  wire logic     p_ready,
    output prod_t         p_data
);

    // stage 1: differences
    logic                    v1_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic signed [ERR_W-1:0] diff_reg;
    logic signed [SAMPLE_W-1:0] prev_meas_reg;

    // stage 2: products
    logic  v2_reg;
    prod_t prod_reg;

    logic ready1;
    logic ready2;
    logic take1;
    logic take2;

    logic signed [ERR_W-1:0]  err_next;
    logic signed [ERR_W-1:0]  diff_next;
    logic signed [PROD_W-1:0] dprod;
    prod_t                    prod_next;

    assign ready2 = !v2_reg || p_ready;
    assign ready1 = !v1_reg || ready2;
    assign take1  = s_valid && ready1;
    assign take2  = v1_reg && ready2;

    assign s_ready = ready1;
    assign p_valid = v2_reg;
    assign p_data  = prod_reg;

    always_comb begin
        err_next  = {s_data.setpoint[SAMPLE_W-1], s_data.setpoint}
                  - {s_data.measured[SAMPLE_W-1], s_data.measured};
        diff_next = {s_data.measured[SAMPLE_W-1], s_data.measured}
                  - {prev_meas_reg[SAMPLE_W-1], prev_meas_reg};

        dprod           = cfg.gain_d * diff_reg;
        prod_next.inc   = cfg.gain_i * err_reg;
        prod_next.pterm = cfg.gain_p * err_reg;
        prod_next.dterm = dprod >>> GAIN_FRAC_BITS;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            prev_meas_reg <= '0;
        end else begin
            if (ready1) begin
                v1_reg <= s_valid;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
            if (take1) begin
                prev_meas_reg <= s_data.measured;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take1) begin
            err_reg  <= err_next;
            diff_reg <= diff_next;
        end
        if (take2) begin
            prod_reg <= prod_next;
        end
    end

endmodule

`default_nettype wire

[hdl/paw_core.sv]
// ----------------------------------------------------------------------------
// paw_core
// integrator with conditional integration, two clamps, result register
// ----------------------------------------------------------------------------
`default_nettype none

module paw_core
    import paw_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = DEF_GAIN_FRAC_BITS,
    parameter int ACC_WIDTH      = DEF_ACC_WIDTH
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire cfg_t  cfg,
    input  wire logic  p_valid,
    output logic       p_ready,
    input  wire prod_t p_data,
    output logic       m_valid,
    input  wire logic  m_ready,
    output out_item_t  m_data
);

    localparam int BASE_W = (ACC_WIDTH > PROD_W) ? ACC_WIDTH : PROD_W;
    localparam int WIDE   = BASE_W + 2;

    localparam logic signed [WIDE-1:0] ACC_HI =
        {{(WIDE-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [WIDE-1:0] ACC_LO =
        {{(WIDE-ACC_WIDTH+1){1'b1}}, {(ACC_WIDTH-1){1'b0}}};

    logic signed [ACC_WIDTH-1:0] integ_reg;
    logic signed [ACC_WIDTH-1:0] integ_next;
    sat_code_t                   clamp_reg;
    sat_code_t                   clamp_next;
    logic                        out_valid_reg;
    out_item_t                   out_data_reg;
    out_item_t                   out_data_next;

    logic                        take;
    logic                        inc_pos;
    logic                        inc_neg;
    logic                        hold;
    logic signed [WIDE-1:0]      inc_w;
    logic signed [WIDE-1:0]      acc_sum;
    logic signed [WIDE-1:0]      pi_sum;
    logic signed [WIDE-1:0]      pi_sh;
    logic signed [WIDE-1:0]      max_w;
    logic signed [WIDE-1:0]      min_w;
    logic signed [SAMPLE_W-1:0]  v1;
    logic signed [WIDE-1:0]      pid_sum;
    logic signed [SAMPLE_W-1:0]  v2;

    assign p_ready = !out_valid_reg || m_ready;
    assign take    = p_valid && p_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_comb begin
        inc_w = {{(WIDE-PROD_W){p_data.inc[PROD_W-1]}}, p_data.inc};
        max_w = {{(WIDE-SAMPLE_W){cfg.out_max[SAMPLE_W-1]}}, cfg.out_max};
        min_w = {{(WIDE-SAMPLE_W){cfg.out_min[SAMPLE_W-1]}}, cfg.out_min};

        // no integration further into a limit that is already clamping
        inc_pos = !p_data.inc[PROD_W-1] && (|p_data.inc);
        inc_neg = p_data.inc[PROD_W-1];
        hold    = ((clamp_reg == SAT_HIGH) && inc_pos)
               || ((clamp_reg == SAT_LOW) && inc_neg);

        acc_sum = {{(WIDE-ACC_WIDTH){integ_reg[ACC_WIDTH-1]}}, integ_reg} + inc_w;
        if (hold) begin
            integ_next = integ_reg;
        end else if (acc_sum > ACC_HI) begin
            integ_next = ACC_HI[ACC_WIDTH-1:0];
        end else if (acc_sum < ACC_LO) begin
            integ_next = ACC_LO[ACC_WIDTH-1:0];
        end else begin
            integ_next = acc_sum[ACC_WIDTH-1:0];
        end

        // p + i, floor shift, first clamp sets the saturation state
        pi_sum = {{(WIDE-PROD_W){p_data.pterm[PROD_W-1]}}, p_data.pterm}
               + {{(WIDE-ACC_WIDTH){integ_next[ACC_WIDTH-1]}}, integ_next};
        pi_sh  = pi_sum >>> GAIN_FRAC_BITS;
        if (pi_sh >= max_w) begin
            v1         = cfg.out_max;
            clamp_next = SAT_HIGH;
        end else if (pi_sh <= min_w) begin
            v1         = cfg.out_min;
            clamp_next = SAT_LOW;
        end else begin
            v1         = pi_sh[SAMPLE_W-1:0];
            clamp_next = SAT_NORMAL;
        end

        // derivative term on measurement, second clamp
        pid_sum = {{(WIDE-SAMPLE_W){v1[SAMPLE_W-1]}}, v1}
                + {{(WIDE-PROD_W){p_data.dterm[PROD_W-1]}}, p_data.dterm};
        if (pid_sum >= max_w) begin
            v2 = cfg.out_max;
        end else if (pid_sum <= min_w) begin
            v2 = cfg.out_min;
        end else begin
            v2 = pid_sum[SAMPLE_W-1:0];
        end

        out_data_next.drive    = v2;
        out_data_next.sat_flag = clamp_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg     <= '0;
            clamp_reg     <= SAT_NORMAL;
            out_valid_reg <= 1'b0;
        end else begin
            if (p_ready) begin
                out_valid_reg <= p_valid;
            end
            if (take) begin
                integ_reg <= integ_next;
                clamp_reg <= clamp_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

[hdl/pid_antiwindup_controller_top.sv]
// ----------------------------------------------------------------------------
// pid_antiwindup_controller_top
// positional pid controller with conditional-integration anti-windup
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake           payload
//   s_        in         s_valid / s_ready   in_item_t  (setpoint, measured)
//   m_        out        m_valid / m_ready   out_item_t (drive, sat_flag)
//   cfg_      in         cfg_we only         cfg_index, cfg_data
//
// one item per cycle sustained while m_ready stays high; an accepted item
// passes the difference register, the product register and the result
// register in that order before m_valid rises
// the integrator and clamp state close their loop inside the result stage,
// so successive items follow each other without gaps
// synchronous active-low reset returns gains and limits to their defaults and
// clears integrator, clamp state and the previous measurement; valid bits of
// all stages drop
// a stall on m_ready holds the result register and backs up the stages;
// s_ready only falls once every stage holds an item
//
// ----------------------------------------------------------------------------
`default_nettype none

module pid_antiwindup_controller_top
    import paw_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = DEF_GAIN_FRAC_BITS,
    parameter int ACC_WIDTH      = DEF_ACC_WIDTH
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input items
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,
    // result items
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data,
    // configuration writes
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg;       // live register values
    logic  p_valid;   // product stage holds an item
    logic  p_ready;   // result stage can take it
    prod_t p_data;    // ki*err, kp*err, floored kd*dmeas

    // gains and clamp limits
    paw_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // error / measurement difference, then the three products
    paw_front #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .p_valid (p_valid),
        .p_ready (p_ready),
        .p_data  (p_data)
    );

    // integrator update, clamps and result register
    paw_core #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .ACC_WIDTH      (ACC_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .p_valid (p_valid),
        .p_ready (p_ready),
        .p_data  (p_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

[hdl/paw_checker.sv]
// ----------------------------------------------------------------------------
// paw_checker
// port-level assertions for the pid controller, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module paw_checker
    import paw_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data
);

    // reset empties the pipeline and opens the input
    ap_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("pipeline not empty after reset");

    // the input only stalls behind a stalled result
    ap_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output backpressure");

    // a waiting result holds
    ap_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // saturation code is always a defined code
    ap_sat_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.sat_flag == SAT_NORMAL) || (m_data.sat_flag == SAT_HIGH)
                 || (m_data.sat_flag == SAT_LOW))
        else $error("undefined saturation code");

endmodule

bind pid_antiwindup_controller_top paw_checker u_paw_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
